/* rtl/pdd_pkg.sv */
// Shared types and constants for the presence detect / debounce / edge block.
// No dependencies; every rtl file imports this package.
package pdd_pkg;

   // Width of each debouncer's age counter.
   localparam int AGE_BITS = 8;
   localparam int TICK_BITS = 8;
   localparam int AGE_CMP_BITS = (AGE_BITS > TICK_BITS) ? AGE_BITS : TICK_BITS;

   localparam int WINDOW_BITS = 12;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 12;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_OVERRIDE_MODE  = 3'd0,
      CSR_DEBOUNCE_TICKS = 3'd1,
      CSR_DETECT_WINDOW  = 3'd2,
      CSR_DETECT_THRESH  = 3'd3,
      CSR_DETECT_INTERVAL = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_FORCE_OFF = 2'd0,
      MODE_FORCE_ON  = 2'd1,
      MODE_AUTO      = 2'd2,
      MODE_AUTO_ALT  = 2'd3
   } mode_type;

   // Detection status as it stands after the current tick.
   typedef struct packed {
      logic done;
      logic detected;
   } det_status_type;

   // Debouncer result for the current tick.
   typedef struct packed {
      logic level;
      logic rise;
   } dbc_out_type;

endpackage

/* rtl/pdd_detect.sv */
// Boot-time board detection: sampling countdown, low streak and window timer.
// Depends on pdd_pkg.
module pdd_detect
   import pdd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   any_low,
   input  logic [WINDOW_BITS-1:0] window_ticks,
   input  logic [7:0]             threshold,
   input  logic [7:0]             interval,
   output det_status_type         status
);

   logic [WINDOW_BITS-1:0] elapsed_ff, elapsed_in;
   logic [7:0]             countdown_ff, countdown_in;
   logic [7:0]             streak_ff, streak_in;
   logic                   detected_ff, detected_in;
   logic                   done_ff, done_in;
   logic [7:0]             streak_inc;

   always_comb begin
      elapsed_in   = elapsed_ff;
      countdown_in = countdown_ff;
      streak_in    = streak_ff;
      detected_in  = detected_ff;
      done_in      = done_ff;
      streak_inc   = (streak_ff != 8'hFF) ? streak_ff + 8'd1 : streak_ff;
      if (!done_ff) begin
         if (elapsed_ff >= window_ticks) begin
            done_in = 1'b1;
         end else begin
            if (countdown_ff == 8'd0) begin
               if (any_low) begin
                  streak_in = streak_inc;
                  if (streak_inc >= threshold) begin
                     detected_in = 1'b1;
                     done_in     = 1'b1;
                  end
               end else begin
                  streak_in = 8'd0;
               end
               // An interval of zero behaves as one: sample on every tick.
               countdown_in = (interval == 8'd0) ? 8'd0 : interval - 8'd1;
            end else begin
               countdown_in = countdown_ff - 8'd1;
            end
            elapsed_in = elapsed_ff + WINDOW_BITS'(1);
            if (elapsed_in >= window_ticks) begin
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         countdown_ff <= '0;
         streak_ff    <= '0;
         detected_ff  <= 1'b0;
         done_ff      <= 1'b0;
      end else if (step) begin
         elapsed_ff   <= elapsed_in;
         countdown_ff <= countdown_in;
         streak_ff    <= streak_in;
         detected_ff  <= detected_in;
         done_ff      <= done_in;
      end
   end

   assign status.done     = done_in;
   assign status.detected = detected_in;

endmodule

/* rtl/pdd_debounce.sv */
// One timer debouncer with a saturating age counter and rising-edge output.
// Depends on pdd_pkg.
module pdd_debounce
   import pdd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 active,
   input  logic                 raw,
   input  logic [TICK_BITS-1:0] debounce_ticks,
   output dbc_out_type          result
);

   logic                raw_last_ff, raw_last_in;
   logic [AGE_BITS-1:0] age_ff, age_in;
   logic                prev_ff, prev_in;
   logic [AGE_CMP_BITS-1:0] age_ext;
   logic [AGE_CMP_BITS-1:0] ticks_ext;
   logic                level;

   always_comb begin
      raw_last_in = raw_last_ff;
      age_in      = (age_ff != '1) ? age_ff + AGE_BITS'(1) : age_ff;
      if (active && (raw != raw_last_ff)) begin
         raw_last_in = raw;
         age_in      = '0;
      end
      age_ext   = AGE_CMP_BITS'(age_in);
      ticks_ext = AGE_CMP_BITS'(debounce_ticks);
      // Until the level has held long enough, the inverse of the last raw value shows.
      level   = (age_ext >= ticks_ext) ? raw_last_in : !raw_last_in;
      prev_in = active ? level : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_last_ff <= 1'b0;
         age_ff      <= '1;
         prev_ff     <= 1'b0;
      end else if (step) begin
         raw_last_ff <= raw_last_in;
         age_ff      <= age_in;
         prev_ff     <= prev_in;
      end
   end

   assign result.level = level;
   assign result.rise  = level && !prev_ff;

endmodule

/* rtl/presence_detect_debounce_edge.sv */
// Top level: configuration registers, detection, three debouncers, sticky
// edge flags and the result register. Depends on pdd_pkg, pdd_detect, pdd_debounce.
//
// Usage: each request beat is one 1 ms tick carrying three active-low pin
// levels and two acknowledge bits. Each accepted beat produces exactly one
// response beat with the debounced coin sense, the sticky button edge flags
// and the detection status.
// The response is registered: it appears in the cycle after the request is
// accepted. Throughput is one beat per cycle while the receiver does not stall;
// the single result register is refilled in the same cycle that its beat is taken.
// When the receiver stalls, the result stays in the register and req_ready
// drops until rsp_ready returns; no beat is lost.
// Configuration writes on the csr_ channel are always accepted and take
// effect for the next tick; write only while no tick is in flight.
// Reset (synchronous, active high) restores the default configuration,
// restarts the detection phase and empties the result register.
module presence_detect_debounce_edge
   import pdd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_sense_level,
   input  logic                      req_button_a_level,
   input  logic                      req_button_b_level,
   input  logic                      req_ack_a,
   input  logic                      req_ack_b,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_coins_ready,
   output logic                      rsp_button_a_pressed,
   output logic                      rsp_button_b_pressed,
   output logic                      rsp_logic_active,
   output logic                      rsp_board_detected,
   output logic                      rsp_detection_done,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [1:0]             mode_ff;
   logic [TICK_BITS-1:0]   debounce_ticks_ff;
   logic [WINDOW_BITS-1:0] window_ff;
   logic [7:0]             threshold_ff;
   logic [7:0]             interval_ff;

   logic                   step;
   logic [2:0]             raw;
   logic                   active;
   det_status_type         det;
   dbc_out_type            dbc [3];
   logic [1:0]             edge_ff, edge_in;
   logic                   rsp_valid_ff;
   logic                   coins_ff, a_ff, b_ff, active_ff, detected_ff, done_ff;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;
   assign raw       = {!req_button_b_level, !req_button_a_level, !req_sense_level};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_AUTO;
         debounce_ticks_ff <= 8'd50;
         window_ff         <= 12'd1000;
         threshold_ff      <= 8'd10;
         interval_ff       <= 8'd10;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OVERRIDE_MODE:   mode_ff           <= csr_wdata[1:0];
            CSR_DEBOUNCE_TICKS:  debounce_ticks_ff <= csr_wdata[TICK_BITS-1:0];
            CSR_DETECT_WINDOW:   window_ff         <= csr_wdata[WINDOW_BITS-1:0];
            CSR_DETECT_THRESH:   threshold_ff      <= csr_wdata[7:0];
            CSR_DETECT_INTERVAL: interval_ff       <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   pdd_detect u_detect (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .any_low      (|raw),
      .window_ticks (window_ff),
      .threshold    (threshold_ff),
      .interval     (interval_ff),
      .status       (det)
   );

   // Mode 3 is taken as automatic.
   assign active = det.done &&
                   ((mode_ff == MODE_FORCE_ON) || (mode_ff >= MODE_AUTO && det.detected));

   for (genvar ch = 0; ch < 3; ch++) begin : g_dbc
      pdd_debounce u_dbc (
         .clock          (clock),
         .reset          (reset),
         .step           (step),
         .active         (active),
         .raw            (raw[ch]),
         .debounce_ticks (debounce_ticks_ff),
         .result         (dbc[ch])
      );
   end

   // Acknowledge clears first, so an edge in the same tick survives.
   always_comb begin
      edge_in[0] = (edge_ff[0] && !req_ack_a) || (active && dbc[1].rise);
      edge_in[1] = (edge_ff[1] && !req_ack_b) || (active && dbc[2].rise);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            edge_ff <= edge_in;
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         coins_ff    <= active ? dbc[0].level : 1'b1;
         a_ff        <= active ? edge_in[0] : 1'b1;
         b_ff        <= active ? edge_in[1] : 1'b0;
         active_ff   <= active;
         detected_ff <= det.detected;
         done_ff     <= det.done;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_coins_ready      = coins_ff;
   assign rsp_button_a_pressed = a_ff;
   assign rsp_button_b_pressed = b_ff;
   assign rsp_logic_active     = active_ff;
   assign rsp_board_detected   = detected_ff;
   assign rsp_detection_done   = done_ff;

`ifndef SYNTH
   a_active_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && active_ff |-> done_ff)
      else $error("logic active before detection finished");

   a_detected_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && detected_ff |-> done_ff)
      else $error("board detected while detection still running");

   a_inactive_passthru: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !active_ff |-> coins_ff && a_ff && !b_ff)
      else $error("pass-through values wrong while logic inactive");

   a_step_fills: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("accepted tick produced no result");
`endif

endmodule

/* sim/pdd_tick_monitor.sv */
// Result predictor and comparator for presence_detect_debounce_edge.
// Watches the req_, rsp_ and csr_ channels; depends on pdd_pkg only.
`timescale 1ns / 1ps

module pdd_tick_monitor
   import pdd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_sense_level,
   input  logic                      req_button_a_level,
   input  logic                      req_button_b_level,
   input  logic                      req_ack_a,
   input  logic                      req_ack_b,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_coins_ready,
   input  logic                      rsp_button_a_pressed,
   input  logic                      rsp_button_b_pressed,
   input  logic                      rsp_logic_active,
   input  logic                      rsp_board_detected,
   input  logic                      rsp_detection_done,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        pending_count
);

   typedef struct packed {
      logic coins_ready;
      logic button_a_pressed;
      logic button_b_pressed;
      logic logic_active;
      logic board_detected;
      logic detection_done;
   } tick_result_type;

   string field_name [6] = '{"detection_done", "board_detected", "logic_active",
                             "button_b_pressed", "button_a_pressed", "coins_ready"};

   mode_type                cfg_mode;
   logic [7:0]              cfg_debounce;
   logic [WINDOW_BITS-1:0]  cfg_window;
   logic [7:0]              cfg_threshold;
   logic [7:0]              cfg_interval;

   logic [WINDOW_BITS-1:0]  boot_elapsed;
   logic [7:0]              sample_countdown;
   logic [7:0]              pressed_run;
   logic                    detected;
   logic                    phase_done;
   logic [2:0]              raw_last;
   logic [2:0]              debounced_prev;
   logic [1:0]              rise_flag;
   logic [AGE_BITS-1:0]     change_age [3];

   tick_result_type         expected_ticks [$];

   function automatic void restore_defaults();
      cfg_mode = MODE_AUTO;
      cfg_debounce = 8'd50;
      cfg_window = 12'd1000;
      cfg_threshold = 8'd10;
      cfg_interval = 8'd10;
      boot_elapsed = '0;
      sample_countdown = '0;
      pressed_run = '0;
      detected = 1'b0;
      phase_done = 1'b0;
      raw_last = '0;
      debounced_prev = '0;
      rise_flag = '0;
      for (int ch = 0; ch < 3; ch++) change_age[ch] = '1;
   endfunction

   // Pins are active low; index 0 is coin sense, 1 and 2 the buttons.
   function automatic tick_result_type advance_tick(input logic sense_pin, input logic a_pin,
                                                    input logic b_pin, input logic ack_a_in,
                                                    input logic ack_b_in);
      logic [2:0]      pressed;
      logic            live;
      logic            level;
      tick_result_type r;
      pressed = ~{b_pin, a_pin, sense_pin};

      if (!phase_done) begin
         if (boot_elapsed >= cfg_window) begin
            phase_done = 1'b1;
         end else begin
            if (sample_countdown == 8'd0) begin
               if (|pressed) begin
                  if (pressed_run != 8'hFF) pressed_run = pressed_run + 8'd1;
                  if (pressed_run >= cfg_threshold) begin
                     detected = 1'b1;
                     phase_done = 1'b1;
                  end
               end else begin
                  pressed_run = 8'd0;
               end
               sample_countdown = (cfg_interval == 8'd0) ? 8'd0 : cfg_interval - 8'd1;
            end else begin
               sample_countdown = sample_countdown - 8'd1;
            end
            boot_elapsed = boot_elapsed + WINDOW_BITS'(1);
            if (boot_elapsed >= cfg_window) phase_done = 1'b1;
         end
      end

      live = phase_done && (cfg_mode == MODE_FORCE_ON ||
             ((cfg_mode == MODE_AUTO || cfg_mode == MODE_AUTO_ALT) && detected));

      for (int ch = 0; ch < 3; ch++) begin
         if (change_age[ch] != '1) change_age[ch] = change_age[ch] + AGE_BITS'(1);
      end

      if (ack_a_in) rise_flag[0] = 1'b0;
      if (ack_b_in) rise_flag[1] = 1'b0;

      // An edge in the same tick as its acknowledge survives, since the clear comes first.
      for (int ch = 0; ch < 3; ch++) begin
         if (live && pressed[ch] != raw_last[ch]) begin
            raw_last[ch] = pressed[ch];
            change_age[ch] = '0;
         end
         level = (change_age[ch] >= cfg_debounce) ? raw_last[ch] : ~raw_last[ch];
         if (live) begin
            if (ch > 0 && level && !debounced_prev[ch]) rise_flag[ch-1] = 1'b1;
            debounced_prev[ch] = level;
         end
      end

      r.coins_ready      = live ? debounced_prev[0] : 1'b1;
      r.button_a_pressed = live ? rise_flag[0] : 1'b1;
      r.button_b_pressed = live ? rise_flag[1] : 1'b0;
      r.logic_active     = live;
      r.board_detected   = detected;
      r.detection_done   = phase_done;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      tick_result_type got;
      tick_result_type want;
      if (reset) begin
         restore_defaults();
         expected_ticks.delete();
         fail_count = 0;
         pending_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_coins_ready, rsp_button_a_pressed, rsp_button_b_pressed,
                   rsp_logic_active, rsp_board_detected, rsp_detection_done};
            if (expected_ticks.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result beat with nothing expected: %b", $realtime, got);
               fail_count++;
            end else begin
               want = expected_ticks.pop_front();
               for (int i = 0; i < 6; i++) begin
                  if (got[i] !== want[i]) begin
                     if (fail_count < 10)
                        $display("%0t: mismatch on %s: expected %b, got %b",
                                 $realtime, field_name[i], want[i], got[i]);
                     fail_count++;
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_ticks.push_back(advance_tick(req_sense_level, req_button_a_level,
                                                  req_button_b_level, req_ack_a, req_ack_b));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_OVERRIDE_MODE:   cfg_mode = mode_type'(csr_wdata[1:0]);
               CSR_DEBOUNCE_TICKS:  cfg_debounce = csr_wdata[7:0];
               CSR_DETECT_WINDOW:   cfg_window = csr_wdata[WINDOW_BITS-1:0];
               CSR_DETECT_THRESH:   cfg_threshold = csr_wdata[7:0];
               CSR_DETECT_INTERVAL: cfg_interval = csr_wdata[7:0];
               default: ;
            endcase
         end
         pending_count = expected_ticks.size();
      end
   end

endmodule

/* sim/testbench.sv */
// Top of the presence_detect_debounce_edge testbench: clock, reset, tick and
// register stimulus, and the verdict. Depends on pdd_pkg, the block and pdd_tick_monitor.
`timescale 1ns / 1ps

module testbench
   import pdd_pkg::*;
();

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_sense_level = 1'b1;
   logic                      req_button_a_level = 1'b1;
   logic                      req_button_b_level = 1'b1;
   logic                      req_ack_a = 1'b0;
   logic                      req_ack_b = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_coins_ready;
   logic                      rsp_button_a_pressed;
   logic                      rsp_button_b_pressed;
   logic                      rsp_logic_active;
   logic                      rsp_board_detected;
   logic                      rsp_detection_done;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int   fail_count;
   int   pending_count;
   logic req_taken = 1'b0;
   logic csr_taken = 1'b0;
   int   send_gap_pct = 0;
   int   recv_stall_pct = 0;

   // Pin levels {sense, a, b} then acks {a, b} for the boot and first active ticks.
   logic [4:0] warmup_ticks [] = '{
      5'b01100, 5'b10100, 5'b11000, 5'b00011, 5'b11100, 5'b11100,
      5'b01100, 5'b10100, 5'b11000, 5'b00000, 5'b01010, 5'b11101};
   logic [4:0] button_ticks [] = '{
      5'b11100, 5'b11100, 5'b00000, 5'b00000, 5'b00011, 5'b00010,
      5'b11100, 5'b11100, 5'b11100, 5'b01100, 5'b11111};

   mode_type phase_mode [8] = '{MODE_AUTO, MODE_FORCE_ON, MODE_AUTO_ALT, MODE_FORCE_OFF,
                               MODE_FORCE_ON, MODE_AUTO, MODE_FORCE_ON, MODE_AUTO};
   int phase_debounce [8] = '{3, 0, 5, 2, 255, 1, 8, 4};
   int phase_items [8]    = '{80, 80, 80, 80, 250, 80, 80, 80};

   presence_detect_debounce_edge dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sense_level(req_sense_level), .req_button_a_level(req_button_a_level),
      .req_button_b_level(req_button_b_level), .req_ack_a(req_ack_a), .req_ack_b(req_ack_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_coins_ready(rsp_coins_ready), .rsp_button_a_pressed(rsp_button_a_pressed),
      .rsp_button_b_pressed(rsp_button_b_pressed), .rsp_logic_active(rsp_logic_active),
      .rsp_board_detected(rsp_board_detected), .rsp_detection_done(rsp_detection_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pdd_tick_monitor u_monitor (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sense_level(req_sense_level), .req_button_a_level(req_button_a_level),
      .req_button_b_level(req_button_b_level), .req_ack_a(req_ack_a), .req_ack_b(req_ack_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_coins_ready(rsp_coins_ready), .rsp_button_a_pressed(rsp_button_a_pressed),
      .rsp_button_b_pressed(rsp_button_b_pressed), .rsp_logic_active(rsp_logic_active),
      .rsp_board_detected(rsp_board_detected), .rsp_detection_done(rsp_detection_done),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Handshakes are recorded at the rising edge and read back at the next falling edge.
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      csr_taken <= csr_valid && csr_ready;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_tick(input logic sense_pin, input logic a_pin, input logic b_pin,
                            input logic ack_a_in, input logic ack_b_in);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_sense_level = sense_pin;
      req_button_a_level = a_pin;
      req_button_b_level = b_pin;
      req_ack_a = ack_a_in;
      req_ack_b = ack_b_in;
      do @(negedge clock); while (!req_taken);
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value[CSR_DATA_BITS-1:0];
      do @(negedge clock); while (!csr_taken);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic quiesce();
      drain();
      repeat (2) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [2:0] pins;
      int         hold;
      int         window;
      int         threshold;
      int         interval;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Forced on during the boot window: the logic must stay off until detection finishes.
      write_csr(CSR_OVERRIDE_MODE, MODE_FORCE_ON);
      write_csr(CSR_DETECT_WINDOW, 60);
      write_csr(CSR_DETECT_THRESH, 3);
      write_csr(CSR_DETECT_INTERVAL, 2);
      foreach (warmup_ticks[i])
         send_tick(warmup_ticks[i][4], warmup_ticks[i][3], warmup_ticks[i][2],
                   warmup_ticks[i][1], warmup_ticks[i][0]);

      quiesce();
      write_csr(CSR_DEBOUNCE_TICKS, 2);
      foreach (button_ticks[i])
         send_tick(button_ticks[i][4], button_ticks[i][3], button_ticks[i][2],
                   button_ticks[i][1], button_ticks[i][0]);

      pins = 3'b111;
      for (int p = 0; p < 8; p++) begin
         quiesce();
         case (p % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
            default: begin send_gap_pct = 10; recv_stall_pct = 10; end
         endcase
         window    = (p == 0) ? 0 : (p == 1) ? 4095 : $urandom_range(1, 4095);
         threshold = (p == 0) ? 0 : (p == 1) ? 255 : $urandom_range(1, 255);
         interval  = (p == 0) ? 0 : (p == 1) ? 255 : $urandom_range(1, 255);
         write_csr(CSR_OVERRIDE_MODE, phase_mode[p]);
         write_csr(CSR_DEBOUNCE_TICKS, phase_debounce[p]);
         write_csr(CSR_DETECT_WINDOW, window);
         write_csr(CSR_DETECT_THRESH, threshold);
         write_csr(CSR_DETECT_INTERVAL, interval);
         // Pins mostly hold for stretches near the debounce time, with some bursts of noise.
         hold = phase_debounce[p] + 2;
         for (int n = 0; n < phase_items[p]; n++) begin
            if (n == phase_items[p] / 2) drain();
            if ($urandom_range(0, 9) == 0) begin
               pins = 3'($urandom_range(0, 7));
            end else begin
               for (int k = 0; k < 3; k++)
                  if ($urandom_range(0, hold) == 0) pins[k] = ~pins[k];
            end
            send_tick(pins[0], pins[1], pins[2],
                      $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
         end
      end

      drain();
      repeat (4) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("presence_detect_debounce_edge verification clean");
      else
         $display("presence_detect_debounce_edge verification failed");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("presence_detect_debounce_edge verification failed");
      $finish;
   end

endmodule
